### design/fp8n_pkg.sv
// Package for the FP8 dot-product neuron: FP8 multiply and add functions.
// No dependencies.
`timescale 1ns / 1ps
package fp8n_pkg;

  localparam int Lanes = 8;

  function automatic logic [7:0] fp8_mul(input logic [7:0] a, input logic [7:0] b);
    logic [3:0] ma, mb;
    logic [7:0] prod;
    logic [2:0] frac;
    logic signed [6:0] ex;
    logic sg;
    ma = {1'b1, a[2:0]};
    mb = {1'b1, b[2:0]};
    sg = a[7] ^ b[7];
    prod = ma * mb;
    ex = $signed({3'b000, a[6:3]}) + $signed({3'b000, b[6:3]}) - 7'sd7;
    if (prod[7]) begin
      frac = prod[6:4];
      ex = ex + 7'sd1;
    end else begin
      frac = prod[5:3];
    end
    if (a[6:0] == 7'd0 || b[6:0] == 7'd0 || ex < 0) begin
      fp8_mul = 8'h00;
    end else if (ex > 7'sd15) begin
      fp8_mul = {sg, 7'h7F};
    end else begin
      fp8_mul = {sg, ex[3:0], frac};
    end
  endfunction

  function automatic logic [7:0] fp8_add(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] big, sml;
    logic signed [6:0] eb;
    logic [4:0] d;
    logic [3:0] fb, fs, fsh;
    logic signed [5:0] sum;
    logic [4:0] mag;
    logic sg;
    if (a[6:0] >= b[6:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    eb = $signed({3'b000, big[6:3]});
    fb = (big[6:0] != 7'd0) ? {1'b1, big[2:0]} : 4'd0;
    fs = (sml[6:0] != 7'd0) ? {1'b1, sml[2:0]} : 4'd0;
    sg = big[7];
    // Big has the larger magnitude, so its exponent is never below the other.
    d = {1'b0, big[6:3]} - {1'b0, sml[6:3]};
    fsh = fs >> d[1:0];
    if (big[7] == sml[7]) begin
      sum = $signed({2'b00, fb}) + $signed({2'b00, fsh});
    end else begin
      sum = $signed({2'b00, fb}) - $signed({2'b00, fsh});
    end
    if (sum < 0) begin
      sg = ~sg;
      sum = -sum;
    end
    mag = sum[4:0];
    if (mag[4]) begin
      eb = eb + 7'sd1;
      mag = mag >> 1;
    end
    for (int k = 0; k < 3; k++) begin
      if (!mag[3]) begin
        eb = eb - 7'sd1;
        mag = mag << 1;
      end
    end
    if (d >= 5'd4) begin
      fp8_add = big;
    end else if (sum == 0 || eb < 0) begin
      fp8_add = 8'h00;
    end else if (eb > 7'sd15) begin
      fp8_add = {sg, 7'h7F};
    end else begin
      fp8_add = {sg, eb[3:0], mag[2:0]};
    end
  endfunction

endpackage

### design/fp8n_lane.sv
// One pipeline stage of the neuron: a registered multiply, then a registered accumulate.
// Depends on fp8n_pkg.
`timescale 1ns / 1ps
module fp8n_lane (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] acc_in,
  input  logic [7:0] x,
  input  logic [7:0] w,
  output logic       out_valid,
  output logic [7:0] acc_out
);
  import fp8n_pkg::*;

  logic       mvalid;
  logic [7:0] prod;
  logic [7:0] acc_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mvalid    <= in_valid;
      out_valid <= mvalid;
    end
    prod    <= fp8_mul(x, w);
    acc_mid <= acc_in;
    acc_out <= fp8_add(acc_mid, prod);
  end
endmodule

### design/fp8_dot_product_neuron.sv
// Top level of the FP8 dot-product neuron; a chain of eight lane stages.
// Depends on fp8n_pkg and fp8n_lane.
`timescale 1ns / 1ps
// A transaction is accepted on every clock edge with start high; busy is always
// low, so one neuron is evaluated per cycle. Each lane has a multiply register
// and then an accumulate register, and the output step adds one more register
// before result appears with done high. The path runs through the chain of
// eight lane units, each holding one FP8 multiply and one FP8 add. The
// receiver cannot stall; done marks each result for one cycle.
module fp8_dot_product_neuron (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] activations,
  input  logic [63:0] weight_word,
  output logic        done,
  output logic [7:0]  result
);
  import fp8n_pkg::*;

  // Operand delay lines: stage i sees row i, registered in step with the lane pipeline.
  logic [63:0] act_d [Lanes];
  logic [63:0] wgt_d [Lanes];
  logic [Lanes:0]    v;
  logic [7:0]        acc [Lanes+1];
  logic [7:0]        sum;

  assign busy   = 1'b0;
  assign v[0]   = start;
  assign acc[0] = weight_word[63:56];
  assign act_d[0] = activations;
  assign wgt_d[0] = weight_word;

  for (genvar i = 1; i < Lanes; i++) begin : g_dly
    logic [63:0] a1, w1;
    always_ff @(posedge clk) begin
      a1 <= act_d[i-1];
      w1 <= wgt_d[i-1];
      act_d[i] <= a1;
      wgt_d[i] <= w1;
    end
  end

  logic [1:0] flg_pipe [2];
  logic [1:0] flags;
  always_ff @(posedge clk) begin
    flg_pipe[0] <= wgt_d[Lanes-1][53:52];
    flg_pipe[1] <= flg_pipe[0];
  end
  assign flags = flg_pipe[1];

  for (genvar i = 0; i < Lanes; i++) begin : g_lane
    fp8n_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .in_valid (v[i]),
      .acc_in   (acc[i]),
      .x        (act_d[i][8*i +: 8]),
      .w        ({wgt_d[i][7*i +: 7], 1'b0}),
      .out_valid(v[i+1]),
      .acc_out  (acc[i+1])
    );
  end

  // Optional compress of the magnitude, then relu on a set sign bit.
  always_comb begin
    sum = acc[Lanes];
    if (flags[0]) begin
      sum = {sum[7], (sum[6:0] >> 1) + 7'h1F};
    end
    if (flags[1] && sum[7]) begin
      sum = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v[Lanes];
    end
    result <= sum;
  end

  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    v[0] |-> ##17 done) else $error("result lost");
  a_relu: assert property (@(posedge clk) disable iff (rst)
    (v[Lanes] && flags[1]) |=> !result[7]) else $error("relu failed");
endmodule

### verif/tb.sv
// Self-checking testbench for the FP8 dot-product neuron (fp8_dot_product_neuron).
// Depends on the RTL top level only; the expected output is computed by its own predictor.
`timescale 1ns / 1ps

// Scoreboard: holds the expected neuron outputs in order of acceptance.
class neuron_scoreboard;
  logic [7:0] pending_q[$];
  int errors;
  int checked;

  function new();
    errors = 0;
    checked = 0;
  endfunction

  // Multiply two FP8 values with truncation, flush and saturation.
  function logic [7:0] fp8_product(logic [7:0] a, logic [7:0] b);
    logic [7:0] sig;
    logic [2:0] frac;
    int ex;
    logic sg;
    if (a[6:0] == 7'd0 || b[6:0] == 7'd0) return 8'h00;
    sg = a[7] ^ b[7];
    sig = {4'b0001, a[2:0]} * {4'b0001, b[2:0]};
    ex = int'(a[6:3]) + int'(b[6:3]) - 7;
    if (sig[7]) begin
      frac = sig[6:4];
      ex = ex + 1;
    end else begin
      frac = sig[5:3];
    end
    if (ex < 0) return 8'h00;
    if (ex > 15) return {sg, 7'h7F};
    return {sg, ex[3:0], frac};
  endfunction

  // Add two FP8 values; the operand of larger magnitude leads, ties to the first.
  function logic [7:0] fp8_sum(logic [7:0] a, logic [7:0] b);
    logic [7:0] hi, lo;
    int eh, el, gap, fh, fl, s;
    logic sg;
    if (a[6:0] >= b[6:0]) begin
      hi = a;
      lo = b;
    end else begin
      hi = b;
      lo = a;
    end
    eh = int'(hi[6:3]);
    el = int'(lo[6:3]);
    fh = (hi[6:0] != 0) ? int'({1'b1, hi[2:0]}) : 0;
    fl = (lo[6:0] != 0) ? int'({1'b1, lo[2:0]}) : 0;
    sg = hi[7];
    gap = eh - el;
    if (gap >= 4) return hi;
    if (gap < 0) gap = 0;
    s = (hi[7] == lo[7]) ? fh + (fl >> gap) : fh - (fl >> gap);
    if (s == 0) return 8'h00;
    if (s < 0) begin
      sg = ~sg;
      s = -s;
    end
    if (s >= 16) begin
      eh = eh + 1;
      s = s >> 1;
    end
    for (int k = 0; k < 3; k++) begin
      if (s < 8) begin
        eh = eh - 1;
        s = s << 1;
      end
    end
    if (eh < 0) return 8'h00;
    if (eh > 15) return {sg, 7'h7F};
    return {sg, eh[3:0], s[2:0]};
  endfunction

  // Full neuron evaluation: bias, eight lanes in order, then compress and relu.
  function logic [7:0] neuron_output(logic [63:0] act, logic [63:0] wts);
    logic [7:0] acc;
    acc = wts[63:56];
    for (int i = 0; i < 8; i++) begin
      acc = fp8_sum(acc, fp8_product(act[8*i +: 8], {wts[7*i +: 7], 1'b0}));
    end
    if (wts[52]) acc = {acc[7], 7'((acc[6:0] >> 1) + 7'h1F)};
    if (wts[53] && acc[7]) acc = 8'h00;
    return acc;
  endfunction

  function void note_input(logic [63:0] act, logic [63:0] wts);
    pending_q.push_back(neuron_output(act, wts));
  endfunction

  // Print one line for a mismatch and count it.
  task report_mismatch(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  task check_result(logic [7:0] got);
    logic [7:0] want;
    checked++;
    if (pending_q.size() == 0) begin
      report_mismatch($sformatf("result 0x%02h arrived with nothing expected", got));
      return;
    end
    want = pending_q.pop_front();
    if (got !== want) begin
      report_mismatch($sformatf("result 0x%02h, expected 0x%02h", got, want));
    end
  endtask
endclass

module tb;
  localparam int Latency = 17;
  localparam int WatchdogLimit = 2000;
  localparam int RandomItems = 1200;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [63:0] activations;
  logic [63:0] weight_word;
  logic        done;
  logic [7:0]  result;

  neuron_scoreboard sb;
  int idle_count;
  int sent;
  bit quiet_stretch;

  fp8_dot_product_neuron u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .activations(activations),
    .weight_word(weight_word),
    .done(done),
    .result(result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // A transaction is taken at the edge where start is high and busy is low.
  // The model is updated in the same edge so the checker sees it in order.
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) begin
        idle_count <= 0;
      end else begin
        idle_count <= idle_count + 1;
      end
      if (start && !busy) begin
        sb.note_input(activations, weight_word);
      end
      if (done) begin
        sb.check_result(result);
      end
    end
  end

  // The watchdog only counts cycles in which nothing moves in either direction.
  always @(posedge clk) begin
    if (idle_count >= WatchdogLimit) begin
      $display("watchdog expired with %0d results outstanding", sb.pending_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one transaction and hold it until the block takes it. A random gap
  // of idle cycles comes first unless the quiet stretch is active.
  task automatic send_neuron(input logic [63:0] act, input logic [63:0] wts);
    if (!quiet_stretch) begin
      while ($urandom_range(99) < 10) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    activations <= act;
    weight_word <= wts;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // Random FP8 value; biased toward the exponent middle so sums stay busy,
  // with occasional zeros and extremes.
  function automatic logic [7:0] pick_fp8();
    case ($urandom_range(9))
      0: return {1'($urandom_range(1)), 7'h00};
      1: return {1'($urandom_range(1)), 7'h7F};
      2, 3: return 8'($urandom);
      default: return {1'($urandom_range(1)), 4'($urandom_range(10, 4)),
                       3'($urandom_range(7))};
    endcase
  endfunction

  function automatic logic [63:0] pick_weights();
    logic [63:0] w;
    for (int i = 0; i < 8; i++) w[7*i +: 7] = 7'(pick_fp8() >> 1);
    w[63:56] = pick_fp8();
    w[55:49] = 7'($urandom);
    return w;
  endfunction

  function automatic logic [63:0] pick_activations();
    logic [63:0] a;
    for (int i = 0; i < 8; i++) a[8*i +: 8] = pick_fp8();
    return a;
  endfunction

  initial begin
    int drain;
    sb = new();
    sent = 0;
    idle_count = 0;
    quiet_stretch = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    activations = '0;
    weight_word = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: all zeros, all ones, each flag alone, cancellation,
    // multiply overflow and underflow, mantissa carry and wide exponent gaps.
    send_neuron('0, '0);
    send_neuron('1, '1);
    send_neuron('0, 64'h0010_0000_0000_0000);            // compress of zero
    send_neuron('0, 64'hB820_0000_0000_0000);            // relu on negative bias
    send_neuron('0, 64'h8030_0000_0000_0000);            // both flags, minus zero
    send_neuron({8{8'h7F}}, {8'h7F, {8{7'h3F}}});        // saturating products
    send_neuron({8{8'hFF}}, {8'hFF, {8{7'h3F}}});
    send_neuron({8{8'h08}}, {8'h00, {8{7'h04}}});        // product underflow
    send_neuron({8{8'h3F}}, {8'h00, {8{7'h1F}}});        // mantissa carry
    send_neuron(64'h0000_0000_0000_00B8, {8'h38, 49'd0, 7'h1C}); // cancellation
    send_neuron(64'h0000_0000_0000_0008, {8'h70, 49'd0, 7'h1C}); // large gap
    send_neuron(64'h0000_0000_0000_0040, {8'h40, 49'd0, 7'h1C}); // equal magnitudes
    send_neuron(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_neuron(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_neuron(64'h8080_8080_8080_8080, 64'h0030_0000_0000_0000);
    send_neuron(64'h3830_2820_1810_0800, 64'hC51C_B162_C183_0E1C);

    // Let the pipeline drain completely before the random part starts.
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);

    for (int n = 0; n < RandomItems; n++) begin
      quiet_stretch = (n >= 400 && n < 600);
      if ($urandom_range(19) == 0)
        send_neuron(64'($urandom) << 32 | 64'($urandom), 64'($urandom) << 32 | 64'($urandom));
      else
        send_neuron(pick_activations(), pick_weights());
    end
    start <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < Latency + 4) begin
      @(posedge clk);
      drain++;
    end

    $display("Sent %0d neuron transactions (directed edge cases, then random) and",
             sent);
    $display("checked %0d results, covering both flags, zeros and saturation.",
             sb.checked);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
